// ===== src/double_to_integer_round_convert_assert.svh =====
// assertion macros for the double-to-integer rounding unit
`ifndef DOUBLE_TO_INTEGER_ROUND_CONVERT_ASSERT_SVH
`define DOUBLE_TO_INTEGER_ROUND_CONVERT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define D2I_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define D2I_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/d2i_pkg.sv =====
package d2i_pkg;

    typedef enum logic [2:0] {
        RM_SEL_CFG = 3'd0,
        RM_ZERO    = 3'd1,
        RM_UP      = 3'd2,
        RM_DOWN    = 3'd3,
        RM_NEAR    = 3'd4
    } round_mode_t;

    typedef enum logic [1:0] {
        REQ_INTEGRAL = 2'd0,
        REQ_SIGNED   = 2'd1,
        REQ_UNSIGNED = 2'd2
    } req_type_t;

    localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_MAX   = 11'h7FF;
    localparam logic [10:0] EXP_BIAS  = 11'd1023;
    localparam logic [10:0] EXP_INT   = 11'd1075;  // exponent where ulp is one
    localparam logic [10:0] EXP_OVF   = 11'd1086;  // 2^63

endpackage

// ===== src/double_to_integer_round_convert.sv =====
// double to integral double / int64 / uint64 rounding unit
// path: each input beat passes the input register, then the result register, to become a result beat
// throughput: one beat per cycle unless stalled; a full skid holds one result and drops s_ready
// reset: aresetn synchronous active low clears valid flags and sets the mode register to nearest
// the round / shift / pack logic sits between the input register and the result register

`include "double_to_integer_round_convert_assert.svh"

module double_to_integer_round_convert (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_operand_bits,
    input  logic [2:0]  s_round_sel,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_bits,
    output logic        m_inexact_flag,
    output logic        m_overflow_flag
);

    // mode register
    logic [2:0] mode_reg;

    // input register stage
    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [63:0] in_x_reg;
    logic [2:0]  in_mode_reg;

    // result register and skid
    logic        out_valid_reg;
    logic [63:0] out_res_reg;
    logic        out_inx_reg;
    logic        out_ovf_reg;
    logic        skid_valid_reg;
    logic [63:0] skid_res_reg;
    logic        skid_inx_reg;
    logic        skid_ovf_reg;

    logic        in_adv;
    logic        out_load;

    assign cfg_ready = 1'b1;

    // stage moves forward when the skid is empty
    assign out_load = in_valid_reg && !skid_valid_reg;
    assign s_ready  = !skid_valid_reg;
    assign in_adv   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= d2i_pkg::RM_NEAR;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // pick the effective mode at the input; selector 0 takes the register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_adv) begin
            in_req_reg  <= s_req_type;
            in_x_reg    <= s_operand_bits;
            in_mode_reg <= (s_round_sel == d2i_pkg::RM_SEL_CFG) ? mode_reg : s_round_sel;
        end
    end

    // ---------------- conversion logic ----------------
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] fr;
    logic [52:0] mant;
    logic [10:0] eff;
    logic        big;          // integer already, shift left
    logic [5:0]  rsh;          // right shift 1..60
    logic        tiny;         // shift beyond 60: all fraction
    logic [5:0]  lsh;          // left shift amount
    logic [63:0] mag_l;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic        rem_nz;
    logic        inc;
    logic [63:0] qr;
    logic [2:0]  md;
    logic [5:0]  msb;
    logic [63:0] packed_v;
    logic [63:0] res;
    logic        inx;
    logic        ovf;
    logic        lz_found;

    always_comb begin
        sgn  = in_x_reg[63];
        ex   = in_x_reg[62:52];
        fr   = in_x_reg[51:0];
        mant = {(ex != 11'd0), fr};
        eff  = (ex != 11'd0) ? ex : 11'd1;
        md   = in_mode_reg;
        if (md < d2i_pkg::RM_ZERO || md > d2i_pkg::RM_NEAR) begin
            md = d2i_pkg::RM_NEAR;
        end
        big  = (eff >= d2i_pkg::EXP_INT);
        tiny = (eff < 11'd1015);
        rsh  = (big || tiny) ? 6'd1 : 6'(d2i_pkg::EXP_INT - eff);
        lsh  = (eff - d2i_pkg::EXP_INT >= 11'd64) ? 6'd0 : 6'(eff - d2i_pkg::EXP_INT);
        mag_l = (eff - d2i_pkg::EXP_INT >= 11'd64) ? 64'd0 : ({11'd0, mant} << lsh);
        if (tiny) begin
            q    = 64'd0;
            rem  = {11'd0, mant};
            half = d2i_pkg::SIGN_BIT;
        end else begin
            q    = {11'd0, mant} >> rsh;
            rem  = {11'd0, mant} & ((64'd1 << rsh) - 64'd1);
            half = 64'd1 << (rsh - 6'd1);
        end
        rem_nz = (rem != 64'd0);
        unique case (md)
            d2i_pkg::RM_UP:   inc = rem_nz && !sgn;
            d2i_pkg::RM_DOWN: inc = rem_nz && sgn;
            d2i_pkg::RM_NEAR: inc = rem_nz && ((rem > half) || (rem == half && q[0]));
            default:          inc = 1'b0;
        endcase
        qr = q + {63'd0, inc};
        // leading one of a value below 2^54
        msb = 6'd0;
        lz_found = 1'b0;
        for (int i = 53; i >= 0; i--) begin
            if (!lz_found && qr[i]) begin
                msb = 6'(i);
                lz_found = 1'b1;
            end
        end
        packed_v = (qr == 64'd0) ? {sgn, 63'd0} :
                   {sgn, d2i_pkg::EXP_BIAS + {5'd0, msb},
                    52'((qr << (6'd52 - msb)))};
        res = 64'd0;
        inx = 1'b0;
        ovf = 1'b0;
        if (ex == d2i_pkg::EXP_MAX) begin
            if (in_req_reg == d2i_pkg::REQ_INTEGRAL) begin
                res = (fr != 52'd0) ? (in_x_reg | d2i_pkg::QUIET_BIT) : in_x_reg;
            end else begin
                res = (fr != 52'd0) ? d2i_pkg::SIGN_BIT : 64'd0;
                ovf = (in_req_reg == d2i_pkg::REQ_SIGNED);
            end
        end else if (big) begin
            if (in_req_reg == d2i_pkg::REQ_INTEGRAL) begin
                res = in_x_reg;
            end else begin
                res = sgn ? (64'd0 - mag_l) : mag_l;
                if (in_req_reg == d2i_pkg::REQ_SIGNED) begin
                    ovf = (!sgn && ex >= d2i_pkg::EXP_OVF) ||
                          (sgn && (ex > d2i_pkg::EXP_OVF ||
                                   (ex == d2i_pkg::EXP_OVF && fr != 52'd0)));
                end
            end
        end else begin
            inx = rem_nz;
            if (in_req_reg == d2i_pkg::REQ_INTEGRAL) begin
                res = packed_v;
            end else begin
                res = sgn ? (64'd0 - qr) : qr;
            end
        end
    end

    // result register with one-deep skid behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_ready) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg || m_ready) begin
                out_valid_reg <= in_valid_reg;
            end else if (in_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_res_reg <= skid_res_reg;
                out_inx_reg <= skid_inx_reg;
                out_ovf_reg <= skid_ovf_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_res_reg <= res;
            out_inx_reg <= inx;
            out_ovf_reg <= ovf;
        end else if (out_load) begin
            skid_res_reg <= res;
            skid_inx_reg <= inx;
            skid_ovf_reg <= ovf;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_bits   = out_res_reg;
    assign m_inexact_flag  = out_inx_reg;
    assign m_overflow_flag = out_ovf_reg;

    `D2I_ASSERT_IMPL(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid full while result empty")
    `D2I_ASSERT_IMPL(a_ovf_signed_only, aclk, aresetn, in_valid_reg && in_req_reg != d2i_pkg::REQ_SIGNED, !ovf, "overflow on non-signed request")
    `D2I_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_bits), "result changed under stall")

endmodule

// ===== tb/sv/double_to_integer_round_convert_checker.sv =====
`timescale 1ns / 1ps

module double_to_integer_round_convert_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_operand_bits,
    input  logic [2:0]  s_round_sel,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_result_bits,
    input  logic        m_inexact_flag,
    input  logic        m_overflow_flag,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [63:0] bits;
        logic        inexact;
        logic        overflow;
    } conv_result_t;

    conv_result_t expected_results[$];
    logic [2:0]   mode_reg;

    function automatic logic [63:0] pack_integral_double(logic sign, logic [63:0] q);
        int          msb;
        logic [63:0] shifted;
        msb = 0;
        if (q == 64'd0) return {sign, 63'd0};
        for (int i = 0; i < 64; i++) if (q[i]) msb = i;
        shifted = q << (52 - msb);
        return {sign, 11'(1023 + msb), shifted[51:0]};
    endfunction

    function automatic conv_result_t convert_double(logic [1:0] req, logic [63:0] x,
                                                    logic [2:0] sel, logic [2:0] cur);
        conv_result_t r;
        logic [2:0]   mode;
        logic         sign;
        logic [10:0]  e;
        logic [51:0]  f;
        logic [63:0]  m, mag, q, rem, half;
        int           sh;
        logic         inc;
        r = '0;
        mode = (sel == d2i_pkg::RM_SEL_CFG) ? cur : sel;
        if (mode < d2i_pkg::RM_ZERO || mode > d2i_pkg::RM_NEAR) mode = d2i_pkg::RM_NEAR;
        sign = x[63];
        e = x[62:52];
        f = x[51:0];
        if (e == d2i_pkg::EXP_MAX) begin
            if (req == d2i_pkg::REQ_INTEGRAL) begin
                r.bits = (f != 0) ? (x | d2i_pkg::QUIET_BIT) : x;
            end else begin
                r.bits = (f != 0) ? d2i_pkg::SIGN_BIT : 64'd0;
                r.overflow = (req == d2i_pkg::REQ_SIGNED);
            end
            return r;
        end
        m = (e != 0) ? {11'd0, 1'b1, f} : {12'd0, f};
        sh = 1075 - ((e != 0) ? int'(e) : 1);
        if (sh <= 0) begin
            mag = (-sh >= 64) ? 64'd0 : (m << (-sh));
            if (req == d2i_pkg::REQ_INTEGRAL) begin
                r.bits = x;
            end else begin
                r.bits = sign ? -mag : mag;
                if (req == d2i_pkg::REQ_SIGNED)
                    r.overflow = sign ? (e > d2i_pkg::EXP_OVF ||
                                         (e == d2i_pkg::EXP_OVF && f != 0))
                                      : (e >= d2i_pkg::EXP_OVF);
            end
            return r;
        end
        if (sh > 60) begin
            q = 0;
            rem = m;
            half = d2i_pkg::SIGN_BIT;
        end else begin
            q = m >> sh;
            rem = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
        end
        inc = 1'b0;
        if (rem != 0) begin
            r.inexact = 1'b1;
            case (mode)
                d2i_pkg::RM_UP:   inc = !sign;
                d2i_pkg::RM_DOWN: inc = sign;
                d2i_pkg::RM_NEAR: inc = (rem > half) || (rem == half && q[0]);
                default:          inc = 1'b0;
            endcase
        end
        if (inc) q = q + 1;
        r.bits = (req == d2i_pkg::REQ_INTEGRAL) ? pack_integral_double(sign, q)
                                                : (sign ? -q : q);
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        conv_result_t want;
        if (!aresetn) begin
            mode_reg <= d2i_pkg::RM_NEAR;
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) mode_reg <= cfg_data;
            if (s_valid && s_ready)
                expected_results.push_back(convert_double(s_req_type, s_operand_bits,
                                                          s_round_sel, mode_reg));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", m_result_bits);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want != {m_result_bits, m_inexact_flag, m_overflow_flag}) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %h ix %b ov %b, got %h ix %b ov %b",
                                     want.bits, want.inexact, want.overflow,
                                     m_result_bits, m_inexact_flag, m_overflow_flag);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/double_to_integer_round_convert_test.sv =====
`timescale 1ns / 1ps

module double_to_integer_round_convert_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [63:0] s_operand_bits = '0;
    logic [2:0]  s_round_sel = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_bits;
    logic        m_inexact_flag;
    logic        m_overflow_flag;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    int          stall_style = 0;

    localparam int CYCLE_LIMIT = 200000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    double_to_integer_round_convert u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_bits(s_operand_bits), .s_round_sel(s_round_sel),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_bits(m_result_bits),
        .m_inexact_flag(m_inexact_flag), .m_overflow_flag(m_overflow_flag)
    );

    double_to_integer_round_convert_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_bits(s_operand_bits), .s_round_sel(s_round_sel),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_bits(m_result_bits),
        .m_inexact_flag(m_inexact_flag), .m_overflow_flag(m_overflow_flag),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls: the pattern changes per phase, style 0 never stalls
    always @(posedge aclk) begin
        case (stall_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= (cycle_count % 7) < 3;
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    int burst_left = 0;

    // one beat; the sender idles between bursts, valid stays up within a burst
    task automatic send_beat(logic [1:0] req, logic [63:0] x, logic [2:0] sel);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_operand_bits <= x;
        s_round_sel <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        // two-stage pipe, let it settle
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(logic [2:0] mode);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // operand shaped toward the interesting exponents: near the binary point and the int64 and uint64 range edges
    function automatic logic [63:0] pick_operand();
        logic [63:0] x;
        logic [10:0] e;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       e = 11'h7FF;
            1:       e = 11'($urandom_range(0, 2));
            2, 3:    e = 11'($urandom_range(1080, 1090));
            4:       e = 11'($urandom_range(0, 2046));
            default: e = 11'($urandom_range(1010, 1076));
        endcase
        x[62:52] = e;
        if ($urandom_range(0, 7) == 0) x[40:0] = '0;
        return x;
    endfunction

    logic [63:0] directed_operands[$] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,  // signed zeros
        64'h3FE0_0000_0000_0000, 64'hBFF8_0000_0000_0000,  // exact halves
        64'h4004_0000_0000_0000, 64'h3FE0_0000_0000_0001,  // 2.5, just above half
        64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,  // subnormals
        64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,  // infinities
        64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,  // nans
        64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,  // +-2^63
        64'hC3E0_0000_0000_0001, 64'h43F0_0000_0000_0000,  // below -2^63, 2^64
        64'h4330_0000_0000_0001, 64'h4320_0000_0000_0001,  // integral edge
        64'h7FEF_FFFF_FFFF_FFFF, 64'h3FEF_FFFF_FFFF_FFFF
    };

    initial begin
        logic [2:0] modes[6];
        modes = '{d2i_pkg::RM_ZERO, d2i_pkg::RM_UP, d2i_pkg::RM_DOWN, d2i_pkg::RM_NEAR,
                  3'd0, 3'd7};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each edge operand once, cycling through the request codes and mode selectors
        foreach (directed_operands[i])
            send_beat(2'(i % 4), directed_operands[i], 3'(i % 8));
        foreach (modes[k])
            send_beat(d2i_pkg::REQ_INTEGRAL, 64'h4004_0000_0000_0000, modes[k]);
        drain_results();

        // random phases, each under a configured mode taken in turn from the list, the last under the unused code 5
        for (int phase = 0; phase < 8; phase++) begin
            stall_style = phase % 4;
            write_mode(phase == 7 ? 3'd5 : modes[phase % 6]);
            repeat (100)
                send_beat(2'($urandom_range(0, 3)), pick_operand(),
                          ($urandom_range(0, 2) == 0) ? d2i_pkg::RM_SEL_CFG
                                                      : 3'($urandom_range(0, 7)));
            drain_results();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
